@@ src/fmga_pkg.sv @@
// shared types and codes for the fifo mutex grant arbiter
package fmga_pkg;

    localparam int ID_W    = 8;
    localparam int OCNT_W  = 16;
    localparam int OWAIT_W = 7;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] requester_id;
    } t_in_beat;

    typedef struct packed {
        logic               grant_valid;
        logic [ID_W-1:0]    granted_id;
        logic [OCNT_W-1:0]  granted_count;
        logic               lock_held;
        logic [OWAIT_W-1:0] waiting_count;
        logic               request_dropped;
    } t_out_beat;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [ID_W-1:0] id;
    } t_q_ctl;

endpackage

@@ src/fmga_queue.sv @@
// waiter queue: circular buffer memory with head, fill and head read forwarding
module fmga_queue
    import fmga_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_q_ctl                               i_ctl,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_fill,
    output logic [ID_W-1:0]                      o_head_id
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH+1);

    logic [ID_W-1:0] mem [QUEUE_DEPTH];

    logic [AW-1:0]   r_head, n_head;
    logic [FW-1:0]   r_fill, n_fill;
    logic [ID_W-1:0] r_rd;
    logic            r_fwd;
    logic [ID_W-1:0] r_fwd_id;
    logic [AW:0]     tail_sum;
    logic [AW-1:0]   tail;

    // tail = (head + fill) mod depth, sum stays below twice the depth
    always_comb begin
        tail_sum = (AW+1)'(r_head) + (AW+1)'(r_fill);
        if (tail_sum >= (AW+1)'(QUEUE_DEPTH)) begin
            tail = AW'(tail_sum - (AW+1)'(QUEUE_DEPTH));
        end else begin
            tail = AW'(tail_sum);
        end
    end

    always_comb begin
        n_head = r_head;
        if (i_ctl.pop) begin
            if (r_head == AW'(QUEUE_DEPTH - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + AW'(1);
            end
        end
        n_fill = r_fill + FW'(i_ctl.push) - FW'(i_ctl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
            r_fwd  <= 1'b0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
            r_fwd  <= i_ctl.push && (r_fill == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[tail] <= i_ctl.id;
        end
        r_rd     <= mem[r_head];
        r_fwd_id <= i_ctl.id;
    end

    assign o_fill    = r_fill;
    assign o_head_id = r_fwd ? r_fwd_id : r_rd;

endmodule

@@ src/fmga_count.sv @@
// grant total table: memory with clearing pass and saturating read-modify-write
module fmga_count
    import fmga_pkg::*;
#(
    parameter int NUM_CLIENTS = 256,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req,
    input  logic [$clog2(NUM_CLIENTS)-1:0] i_slot,
    output logic                           o_ready,
    output logic [COUNT_WIDTH-1:0]         o_count
);

    localparam int SW = $clog2(NUM_CLIENTS);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] mem [NUM_CLIENTS];

    logic                   r_clr;
    logic [SW-1:0]          r_clr_addr;
    logic                   r_pend;
    logic [SW-1:0]          r_slot;
    logic [COUNT_WIDTH-1:0] r_rd;
    logic [COUNT_WIDTH-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_pend <= i_req;
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + SW'(1);
                if (r_clr_addr == SW'(NUM_CLIENTS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
        end
    end

    // saturating increment
    always_comb begin
        if (r_rd == CNT_MAX) begin
            n_cnt = r_rd;
        end else begin
            n_cnt = r_rd + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            mem[r_clr_addr] <= '0;
        end else if (r_pend) begin
            mem[r_slot] <= n_cnt;
        end
        r_rd   <= mem[i_slot];
        r_slot <= i_slot;
    end

    assign o_ready = !r_clr;
    assign o_count = n_cnt;

endmodule

@@ src/fifo_mutex_grant_arbiter_unit.sv @@
// top level of the fifo mutex grant arbiter: command control and result register
//
//  channel   | ports                       | handshake
//  ----------+-----------------------------+---------------------------------
//  command   | start, busy, i_item         | beat taken when start && !busy
//  result    | o_strobe, o_result          | one cycle per beat, no backpressure
//
// one command beat passes through accept with queue update and head read,
// counter table read and counter write back in turn; the result strobe
// follows. the two memory reads lie in series on this path.
// after reset a clearing pass over all NUM_CLIENTS entries zeroes the
// counter table, busy stays high for its length. results cannot be stalled.
module fifo_mutex_grant_arbiter_unit
    import fmga_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int NUM_CLIENTS = 256,
    parameter int COUNT_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_beat  i_item,
    output logic      o_strobe,
    output t_out_beat o_result
);

    localparam int FW      = $clog2(QUEUE_DEPTH+1);
    localparam int SW      = $clog2(NUM_CLIENTS);
    localparam int ID_SPAN = 2 ** ID_W;

    typedef logic [SW-1:0] t_slot_lut [ID_SPAN];

    function automatic t_slot_lut f_mk_lut();
        t_slot_lut lut;
        for (int i = 0; i < ID_SPAN; i++) begin
            lut[i] = SW'(i % NUM_CLIENTS);
        end
        return lut;
    endfunction

    localparam t_slot_lut SLOT_LUT = f_mk_lut();

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_QRD   = 4'b0100,
        S_CRD   = 4'b1000
    } t_state;

    t_state    r_state, n_state;
    logic      r_lock, n_lock;
    logic      r_grant;
    logic      r_drop;
    logic      r_grant2;
    logic      r_drop2;
    logic      r_lock2;
    logic [ID_W-1:0]    r_gid;
    logic [OWAIT_W-1:0] r_wait;
    logic      r_strobe;
    t_out_beat r_result;

    t_q_ctl          q_ctl;
    logic [FW-1:0]   q_fill;
    logic [ID_W-1:0] q_head_id;
    logic            c_ready;
    logic [COUNT_WIDTH-1:0] c_count;
    logic            accept;
    logic            is_full;
    logic            push;
    logic            grant;
    logic [31:0]     fill_ext;
    logic [31:0]     cnt_ext;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign is_full = (q_fill == FW'(QUEUE_DEPTH));

    always_comb begin
        push   = 1'b0;
        grant  = 1'b0;
        n_lock = r_lock;
        if (i_item.cmd == CMD_REQUEST) begin
            push  = !is_full;
            grant = !is_full && !r_lock;
            if (!is_full) begin
                n_lock = 1'b1;
            end
        end else begin
            grant  = (q_fill != '0);
            n_lock = grant;
        end
        q_ctl.push = accept && push;
        q_ctl.pop  = accept && grant;
        q_ctl.id   = i_item.requester_id;
    end

    fmga_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (q_ctl),
        .o_fill   (q_fill),
        .o_head_id(q_head_id)
    );

    fmga_count #(
        .NUM_CLIENTS(NUM_CLIENTS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_count (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  ((r_state == S_QRD) && r_grant),
        .i_slot (SLOT_LUT[q_head_id]),
        .o_ready(c_ready),
        .o_count(c_count)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (c_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_QRD;
                end
            end
            S_QRD:   n_state = S_CRD;
            S_CRD:   n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    assign fill_ext = 32'(q_fill);
    assign cnt_ext  = 32'(c_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_lock   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_CRD);
            if (accept) begin
                r_lock <= n_lock;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_grant <= grant;
            r_drop  <= (i_item.cmd == CMD_REQUEST) && is_full;
            r_lock2 <= n_lock;
        end
        if (r_state == S_QRD) begin
            r_grant2 <= r_grant;
            r_drop2  <= r_drop;
            r_gid    <= r_grant ? q_head_id : '0;
            r_wait   <= fill_ext[OWAIT_W-1:0];
        end
        if (r_state == S_CRD) begin
            r_result.grant_valid     <= r_grant2;
            r_result.granted_id      <= r_gid;
            r_result.granted_count   <= r_grant2 ? cnt_ext[OCNT_W-1:0] : '0;
            r_result.lock_held       <= r_lock2;
            r_result.waiting_count   <= r_wait;
            r_result.request_dropped <= r_drop2;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_strobe_after_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> $past(r_state == S_CRD))
        else $error("result beat without a counter stage");

    a_grant_holds_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.grant_valid |-> o_result.lock_held && !o_result.request_dropped)
        else $error("grant reported without lock held");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_fill <= FW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !c_ready |-> busy)
        else $error("command port open during clearing pass");

endmodule
